>>> rtl/bcf_pkg.sv
package bcf_pkg;

  // Coordinate format of one control point and of one emitted point.
  localparam int COORD_BITS = 16;
  localparam int POINT_BITS = 3 * COORD_BITS;

  // Largest step count that the flattener honors; larger requests saturate.
  localparam int MAX_STEPS = 63;
  localparam int STEP_BITS = 6;

  // The curve parameter t is unsigned Q0.16.
  localparam int FRAC_BITS = 16;
  localparam int ONE_Q16   = 65536;

  // Working set of the de Casteljau evaluation: up to four control points.
  localparam int NUM_CTRL = 4;

  typedef enum logic [1:0] {
    CMD_POINT = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_QUAD  = 2'd2,
    CMD_CUBIC = 2'd3
  } bcf_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DISPATCH,
    ST_EMIT_A,
    ST_LOAD,
    ST_BLEND,
    ST_WAIT,
    ST_DROP,
    ST_EMIT,
    ST_ADVANCE
  } bcf_state_t;

  // One 3-D point, packed z:y:x with x in the low bits.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } bcf_vec_t;

  typedef struct packed {
    logic [1:0]            command;
    logic [POINT_BITS-1:0] point_a;
    logic [POINT_BITS-1:0] point_b;
    logic [POINT_BITS-1:0] point_c;
    logic [POINT_BITS-1:0] point_d;
    logic [STEP_BITS-1:0]  step_count;
  } bcf_in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         last_point;
  } bcf_out_word_t;

  // Request to the blend unit.
  typedef struct packed {
    logic                 start;
    logic [FRAC_BITS-1:0] frac;
  } bcf_blend_req_t;

  // Result of the reciprocal divider: 65536 = quot * steps + rem.
  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS:0]   quot;
    logic [STEP_BITS-1:0] rem;
  } bcf_recip_res_t;

endpackage

>>> rtl/bezier_curve_flattener.sv
// Bezier curve flattener. Each input word carries a segment command (point,
// line, quadratic or cubic), up to four control points packed z:y:x as signed
// 16-bit coordinates, and a step count saturated to 63. The block emits the
// flattened points of the segment in order, the final one marked by
// last_point: a point emits itself, a line emits its start point and then
// lerp(a,b,i/steps) for i = 0..steps-1, a quadratic emits the de Casteljau
// points for i = 1..steps-1, and a cubic for i = 0..steps-1. The parameter t
// is floor(i*65536/steps) and every blend rounds toward minus infinity.
// Timing: in_ready is high only while no segment is in progress. Every
// segment, a single point included, first runs a bit-serial division of
// 65536 by the step count, after which t advances by add and compare. Each
// point is then evaluated on one shared three-lane blend unit (a multiplier
// per coordinate, two pipeline stages), and an emitted point waits in the
// output register until out_ready takes it. Points and zero-step lines emit
// only the start point and use no blend.
module bezier_curve_flattener (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  bcf_pkg::bcf_in_word_t   in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bcf_pkg::bcf_out_word_t  out_word
);

  localparam int SB = bcf_pkg::STEP_BITS;
  localparam int NC = bcf_pkg::NUM_CTRL;
  localparam int TB = bcf_pkg::FRAC_BITS + 1;

  bcf_pkg::bcf_state_t     state_r, state_nxt;
  bcf_pkg::bcf_cmd_t       cmd_r;
  bcf_pkg::bcf_vec_t       ctrl_r [NC];
  bcf_pkg::bcf_vec_t       w_r [NC];
  bcf_pkg::bcf_vec_t       w_nxt [NC];
  logic [SB-1:0]           steps_r, steps_in;
  logic [SB-1:0]           idx_r, idx_nxt;
  logic [TB-1:0]           t_r, t_nxt;
  logic [SB-1:0]           rem_r, rem_nxt;
  logic [SB:0]             rem_sum;
  logic                    rem_wrap;
  logic [2:0]              lvl_r, lvl_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  bcf_pkg::bcf_out_word_t  out_word_r, out_word_nxt;
  logic                    accept;
  logic                    emit_first_last;

  bcf_pkg::bcf_blend_req_t blend_req;
  logic                    blend_done;
  bcf_pkg::bcf_vec_t       blend_res;
  bcf_pkg::bcf_recip_res_t recip;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == bcf_pkg::ST_IDLE);
  assign steps_in = (in_word.step_count > SB'(bcf_pkg::MAX_STEPS)) ?
                    SB'(bcf_pkg::MAX_STEPS) : in_word.step_count;

  // Step increment for t: 65536 / steps, computed once per segment from the
  // captured step count.
  bcf_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .divisor (steps_r),
    .res     (recip)
  );

  // Shared blend unit always combines the first two working points.
  assign blend_req.start = (state_r == bcf_pkg::ST_BLEND);
  assign blend_req.frac  = t_r[bcf_pkg::FRAC_BITS-1:0];

  bcf_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (blend_req),
    .p      (w_r[0]),
    .q      (w_r[1]),
    .done   (blend_done),
    .result (blend_res)
  );

  // Exact stepping of t = floor(i*65536/steps) by quotient and remainder.
  assign rem_sum  = {1'b0, rem_r} + {1'b0, recip.rem};
  assign rem_wrap = rem_sum >= {1'b0, steps_r};

  assign emit_first_last = (cmd_r == bcf_pkg::CMD_POINT) || (steps_r == '0);

  // Sequencer: next state, working set, t stepping and the output register.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    lvl_nxt       = lvl_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    for (int j = 0; j < NC; j++) begin
      w_nxt[j] = w_r[j];
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bcf_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = bcf_pkg::ST_DIV;
        end
      end
      bcf_pkg::ST_DIV: begin
        idx_nxt = '0;
        t_nxt   = '0;
        rem_nxt = '0;
        if (recip.done) begin
          state_nxt = bcf_pkg::ST_DISPATCH;
        end
      end
      bcf_pkg::ST_DISPATCH: begin
        case (cmd_r)
          bcf_pkg::CMD_POINT, bcf_pkg::CMD_LINE: begin
            state_nxt = bcf_pkg::ST_EMIT_A;
          end
          bcf_pkg::CMD_QUAD: begin
            state_nxt = (steps_r < SB'(2)) ? bcf_pkg::ST_IDLE : bcf_pkg::ST_ADVANCE;
          end
          default: begin
            state_nxt = (steps_r == '0) ? bcf_pkg::ST_IDLE : bcf_pkg::ST_LOAD;
          end
        endcase
      end
      bcf_pkg::ST_EMIT_A: begin
        // The start point itself, for point and line segments.
        if (!out_valid_r) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.coord_x    = ctrl_r[0].x;
          out_word_nxt.coord_y    = ctrl_r[0].y;
          out_word_nxt.coord_z    = ctrl_r[0].z;
          out_word_nxt.last_point = emit_first_last;
          state_nxt = emit_first_last ? bcf_pkg::ST_IDLE : bcf_pkg::ST_LOAD;
        end
      end
      bcf_pkg::ST_LOAD: begin
        for (int j = 0; j < NC; j++) begin
          w_nxt[j] = ctrl_r[j];
        end
        lvl_nxt   = 3'({1'b0, cmd_r}) + 3'd1;
        cnt_nxt   = cmd_r;
        state_nxt = bcf_pkg::ST_BLEND;
      end
      bcf_pkg::ST_BLEND: begin
        state_nxt = bcf_pkg::ST_WAIT;
      end
      bcf_pkg::ST_WAIT: begin
        // Consume the front point and append the blend at the level's tail.
        if (blend_done) begin
          for (int j = 0; j < NC - 1; j++) begin
            w_nxt[j] = w_r[j+1];
          end
          w_nxt[2'(lvl_r - 3'd1)] = blend_res;
          if (cnt_r == 2'd1) begin
            state_nxt = bcf_pkg::ST_DROP;
          end else begin
            cnt_nxt   = cnt_r - 2'd1;
            state_nxt = bcf_pkg::ST_BLEND;
          end
        end
      end
      bcf_pkg::ST_DROP: begin
        // Discard the last point of the finished level.
        for (int j = 0; j < NC - 1; j++) begin
          w_nxt[j] = w_r[j+1];
        end
        lvl_nxt = lvl_r - 3'd1;
        if (lvl_r == 3'd2) begin
          state_nxt = bcf_pkg::ST_EMIT;
        end else begin
          cnt_nxt   = 2'(lvl_r - 3'd2);
          state_nxt = bcf_pkg::ST_BLEND;
        end
      end
      bcf_pkg::ST_EMIT: begin
        if (!out_valid_r) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.coord_x    = w_r[0].x;
          out_word_nxt.coord_y    = w_r[0].y;
          out_word_nxt.coord_z    = w_r[0].z;
          out_word_nxt.last_point = (idx_r == steps_r - SB'(1));
          state_nxt = (idx_r == steps_r - SB'(1)) ? bcf_pkg::ST_IDLE
                                                  : bcf_pkg::ST_ADVANCE;
        end
      end
      bcf_pkg::ST_ADVANCE: begin
        idx_nxt   = idx_r + SB'(1);
        t_nxt     = t_r + recip.quot + TB'(rem_wrap);
        rem_nxt   = rem_wrap ? SB'(rem_sum - {1'b0, steps_r}) : rem_sum[SB-1:0];
        state_nxt = bcf_pkg::ST_LOAD;
      end
      default: begin
        state_nxt = bcf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= bcf_pkg::bcf_cmd_t'(in_word.command);
      ctrl_r[0] <= in_word.point_a;
      ctrl_r[1] <= in_word.point_b;
      ctrl_r[2] <= in_word.point_c;
      ctrl_r[3] <= in_word.point_d;
      steps_r   <= steps_in;
    end
    for (int j = 0; j < NC; j++) begin
      w_r[j] <= w_nxt[j];
    end
    idx_r      <= idx_nxt;
    t_r        <= t_nxt;
    rem_r      <= rem_nxt;
    lvl_r      <= lvl_nxt;
    cnt_r      <= cnt_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The blend unit only finishes while the sequencer waits for it.
  a_blend_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    blend_done |-> state_r == bcf_pkg::ST_WAIT)
    else $error("blend result arrived outside the wait state");

  // The divider only finishes during the division phase of a segment.
  a_recip_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    recip.done |-> state_r == bcf_pkg::ST_DIV)
    else $error("divider finished outside the division phase");

  // A point is evaluated only for an index below the step count.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bcf_pkg::ST_LOAD |-> idx_r < steps_r)
    else $error("point index ran past the step count");

  // A level is never dropped below a single remaining point.
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bcf_pkg::ST_DROP |-> lvl_r >= 3'd2 && lvl_r <= 3'd4)
    else $error("de Casteljau level size out of range");

  // A point taken in the emit state is presented on the output next cycle.
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcf_pkg::ST_EMIT && !out_valid_r) |=> out_valid_r)
    else $error("emitted point was not presented on the output");

endmodule

>>> rtl/bcf_recip.sv
module bcf_recip (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [bcf_pkg::STEP_BITS-1:0]       divisor,
  output bcf_pkg::bcf_recip_res_t             res
);

  localparam int QBITS = bcf_pkg::FRAC_BITS + 1;
  localparam int CBITS = $clog2(QBITS);
  localparam logic [QBITS-1:0] DIVIDEND = QBITS'(bcf_pkg::ONE_Q16);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CBITS-1:0]              cnt_r, cnt_nxt;
  logic [QBITS-1:0]              quot_r, quot_nxt;
  logic [bcf_pkg::STEP_BITS-1:0] rem_r, rem_nxt;
  logic [bcf_pkg::STEP_BITS:0]   trial;
  logic                          fits;

  // One quotient bit per cycle, restoring division of 65536 by the step count.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, DIVIDEND[cnt_r]};
    fits     = trial >= {1'b0, divisor};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CBITS'(QBITS - 1);
      quot_nxt = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[QBITS-2:0], fits};
      rem_nxt  = fits ? bcf_pkg::STEP_BITS'(trial - {1'b0, divisor})
                      : trial[bcf_pkg::STEP_BITS-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CBITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule

>>> rtl/bcf_blend.sv
module bcf_blend (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bcf_pkg::bcf_blend_req_t  req,
  input  bcf_pkg::bcf_vec_t        p,
  input  bcf_pkg::bcf_vec_t        q,
  output logic                     done,
  output bcf_pkg::bcf_vec_t        result
);

  localparam int CB = bcf_pkg::COORD_BITS;
  localparam int FB = bcf_pkg::FRAC_BITS;
  localparam int PW = CB + FB + 2;

  logic [2:0][CB-1:0]         p_lane, q_lane;
  logic signed [CB:0]         diff [3];
  logic signed [FB:0]         frac_s;
  logic signed [PW-1:0]       prod_nxt [3];
  logic signed [PW-1:0]       prod_r [3];
  logic [2:0][CB-1:0]         base_r;
  logic [2:0][CB-1:0]         res_nxt;
  logic [2:0][CB-1:0]         res_r;
  logic                       v1_r, done_r;

  assign p_lane = p;
  assign q_lane = q;
  assign frac_s = $signed({1'b0, req.frac});

  // Stage one: (q - p) * t for each of the three lanes.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]     = $signed({q_lane[k][CB-1], q_lane[k]}) -
                    $signed({p_lane[k][CB-1], p_lane[k]});
      prod_nxt[k] = diff[k] * frac_s;
    end
  end

  // Stage two: p + floor(product / 65536); the blend stays between p and q.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res_nxt[k] = base_r[k] + prod_r[k][CB+FB-1:FB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
    base_r <= p_lane;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> tb/bcf_checker.sv
module bcf_checker
  import bcf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  bcf_in_word_t  in_word,
  input  logic          out_valid,
  input  logic          out_ready,
  input  bcf_out_word_t out_word,
  output int            mismatches,
  output int            points_pending,
  output int            segments_seen,
  output int            points_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Only the first few mismatches are printed; all of them are counted.
  localparam int PRINT_CAP = 30;

  bcf_out_word_t curve_points_due[$];
  int error_count = 0;
  int pending_count = 0;
  int segment_count = 0;
  int point_count = 0;

  assign mismatches     = error_count;
  assign points_pending = pending_count;
  assign segments_seen  = segment_count;
  assign points_seen    = point_count;

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) begin
      $display("[%0t] MISMATCH at point %0d: %s", $realtime, point_count, msg);
    end
    error_count++;
  endtask

  // One blend step, rounded toward minus infinity.
  function automatic longint blend_q16(input longint p, input longint q, input longint t);
    return (p * (ONE_Q16 - t) + q * t) >>> FRAC_BITS;
  endfunction

  // De Casteljau evaluation of one coordinate at parameter t.
  function automatic longint curve_coord(input bcf_cmd_t cmd, input longint a,
                                         input longint b, input longint c,
                                         input longint d, input longint t);
    longint u;
    longint v;
    longint w;
    u = blend_q16(a, b, t);
    v = blend_q16(b, c, t);
    w = blend_q16(c, d, t);
    case (cmd)
      CMD_LINE:  return u;
      CMD_QUAD:  return blend_q16(u, v, t);
      CMD_CUBIC: return blend_q16(blend_q16(u, v, t), blend_q16(v, w, t), t);
      default:   return a;
    endcase
  endfunction

  function automatic void push_point(input longint x, input longint y, input longint z,
                                     input logic is_last);
    bcf_out_word_t p;
    p.coord_x    = x[COORD_BITS-1:0];
    p.coord_y    = y[COORD_BITS-1:0];
    p.coord_z    = z[COORD_BITS-1:0];
    p.last_point = is_last;
    curve_points_due = {curve_points_due, p};
  endfunction

  // Expands one segment word into the points it must produce.
  function automatic void predict_segment(input bcf_in_word_t w);
    bcf_vec_t pa;
    bcf_vec_t pb;
    bcf_vec_t pc;
    bcf_vec_t pd;
    bcf_cmd_t cmd;
    longint steps;
    longint first_i;
    longint i;
    longint t;
    pa = w.point_a;
    pb = w.point_b;
    pc = w.point_c;
    pd = w.point_d;
    cmd = bcf_cmd_t'(w.command);
    steps = w.step_count;
    if (steps > MAX_STEPS) steps = MAX_STEPS;
    // A point is emitted alone; a line opens with its start point.
    if (cmd == CMD_POINT || cmd == CMD_LINE) begin
      push_point(pa.x, pa.y, pa.z, cmd == CMD_POINT || steps == 0);
    end
    if (cmd != CMD_POINT) begin
      first_i = (cmd == CMD_QUAD) ? 1 : 0;
      for (i = first_i; i < steps; i++) begin
        t = (i * ONE_Q16) / steps;
        push_point(curve_coord(cmd, pa.x, pb.x, pc.x, pd.x, t),
                   curve_coord(cmd, pa.y, pb.y, pc.y, pd.y, t),
                   curve_coord(cmd, pa.z, pb.z, pc.z, pd.z, t),
                   i == steps - 1);
      end
    end
  endfunction

  // Compare each accepted output word with the oldest predicted point, then
  // expand each accepted segment word.
  always @(posedge clk) begin : watch_channels
    bcf_out_word_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (curve_points_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word x=%0d y=%0d z=%0d last=%0b",
                                    out_word.coord_x, out_word.coord_y,
                                    out_word.coord_z, out_word.last_point));
        end else begin
          want = curve_points_due.pop_front();
          if (out_word.coord_x !== want.coord_x)
            report_mismatch($sformatf("coord_x got %0d expected %0d",
                                      out_word.coord_x, want.coord_x));
          if (out_word.coord_y !== want.coord_y)
            report_mismatch($sformatf("coord_y got %0d expected %0d",
                                      out_word.coord_y, want.coord_y));
          if (out_word.coord_z !== want.coord_z)
            report_mismatch($sformatf("coord_z got %0d expected %0d",
                                      out_word.coord_z, want.coord_z));
          if (out_word.last_point !== want.last_point)
            report_mismatch($sformatf("last_point got %0b expected %0b",
                                      out_word.last_point, want.last_point));
        end
        point_count++;
      end
      if (in_valid && in_ready) begin
        segment_count++;
        predict_segment(in_word);
      end
    end
    pending_count <= curve_points_due.size();
  end

endmodule

>>> tb/tb_bezier_curve_flattener.sv
module tb_bezier_curve_flattener;
  timeunit 1ns;
  timeprecision 1ps;
  import bcf_pkg::*;

  localparam int RANDOM_PER_PHASE = 80;
  localparam int QUIET_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 100;

  localparam logic [POINT_BITS-1:0] PT_MIN  = {3{16'h8000}};
  localparam logic [POINT_BITS-1:0] PT_MAX  = {3{16'h7fff}};
  localparam logic [POINT_BITS-1:0] PT_ONES = {3{16'hffff}};
  localparam logic [POINT_BITS-1:0] PT_ZERO = '0;
  localparam logic [POINT_BITS-1:0] PT_MIX  = {16'h0000, 16'h7fff, 16'h8000};

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  bcf_in_word_t  in_word = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  bcf_out_word_t out_word;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int mismatches;
  int points_pending;
  int segments_seen;
  int points_seen;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bezier_curve_flattener dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  bcf_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .mismatches     (mismatches),
    .points_pending (points_pending),
    .segments_seen  (segments_seen),
    .points_seen    (points_seen)
  );

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d points still due",
               QUIET_LIMIT, points_pending);
      $display("bezier_curve_flattener verification failed");
      $finish;
    end
  end

  function automatic bcf_in_word_t make_segment(input bcf_cmd_t cmd,
                                                input logic [POINT_BITS-1:0] a,
                                                input logic [POINT_BITS-1:0] b,
                                                input logic [POINT_BITS-1:0] c,
                                                input logic [POINT_BITS-1:0] d,
                                                input int steps);
    bcf_in_word_t w;
    w.command    = cmd;
    w.point_a    = a;
    w.point_b    = b;
    w.point_c    = c;
    w.point_d    = d;
    w.step_count = steps[STEP_BITS-1:0];
    return w;
  endfunction

  // Coordinates lean toward the range ends, where the blend is most stressed.
  function automatic logic [COORD_BITS-1:0] random_coord();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [POINT_BITS-1:0] random_point();
    return {random_coord(), random_coord(), random_coord()};
  endfunction

  // Most segments are short; a few use the full step range.
  function automatic bcf_in_word_t random_segment();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) pick = MAX_STEPS;
    else if (pick < 20) pick = $urandom_range(MAX_STEPS);
    else pick = $urandom_range(8);
    return make_segment(bcf_cmd_t'($urandom_range(3)), random_point(), random_point(),
                        random_point(), random_point(), pick);
  endfunction

  // Offers one segment word, with random idle cycles first, and returns at
  // the edge where it is accepted.
  task automatic send_segment(input bcf_in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin : run_stimulus
    int phase;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        // Single points, two of them carrying junk in the fields they do not use.
        send_segment(make_segment(CMD_POINT, PT_MIX, PT_ZERO, PT_ZERO, PT_ZERO, 0));
        send_segment(make_segment(CMD_POINT, PT_ONES, PT_MAX, PT_MIN, PT_MIX, MAX_STEPS));
        send_segment(make_segment(CMD_POINT, PT_MIN, PT_MAX, PT_MAX, PT_MAX, 5));
        // Lines: zero steps gives only the start point, then growing counts.
        send_segment(make_segment(CMD_LINE, PT_MAX, PT_MIN, PT_ZERO, PT_ZERO, 0));
        send_segment(make_segment(CMD_LINE, PT_MIN, PT_MAX, PT_ZERO, PT_ZERO, 1));
        send_segment(make_segment(CMD_LINE, PT_ZERO, PT_ONES, PT_ZERO, PT_ZERO, 2));
        send_segment(make_segment(CMD_LINE, PT_MAX, PT_MIN, PT_ONES, PT_MIX, 7));
        send_segment(make_segment(CMD_LINE, PT_MIN, PT_MAX, PT_MIX, PT_ONES, MAX_STEPS));
        // Quadratics: below two steps produce nothing, then two and the full step count.
        send_segment(make_segment(CMD_QUAD, PT_MIN, PT_MAX, PT_MIN, PT_ZERO, 0));
        send_segment(make_segment(CMD_QUAD, PT_MIN, PT_MAX, PT_MIN, PT_ZERO, 1));
        send_segment(make_segment(CMD_QUAD, PT_MIN, PT_MAX, PT_MIN, PT_MAX, 2));
        send_segment(make_segment(CMD_QUAD, PT_MAX, PT_MIN, PT_MAX, PT_ONES, MAX_STEPS));
        // Cubics: zero steps produce nothing, then growing counts.
        send_segment(make_segment(CMD_CUBIC, PT_MIN, PT_MAX, PT_MIN, PT_MAX, 0));
        send_segment(make_segment(CMD_CUBIC, PT_MIN, PT_MAX, PT_MIN, PT_MAX, 1));
        send_segment(make_segment(CMD_CUBIC, PT_MIN, PT_MAX, PT_MIN, PT_MAX, 3));
        send_segment(make_segment(CMD_CUBIC, PT_MAX, PT_MIN, PT_MAX, PT_MIN, MAX_STEPS));
        send_segment(make_segment(CMD_CUBIC, PT_MIX, PT_ONES, PT_ZERO, PT_MIN, MAX_STEPS));
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_segment(random_segment());
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d segment words sent, %0d curve points compared,", segments_seen,
             points_seen);
    $display("Summary: under sender-heavy, receiver-heavy and back-to-back traffic.");
    if (mismatches == 0) begin
      $display("bezier_curve_flattener verification clean");
    end else begin
      $display("bezier_curve_flattener verification failed");
    end
    $finish;
  end

endmodule
